/* rtl/core/psw_pkg.sv */
// Shared types, codes and widths of the periodic slot wheel table.
package psw_pkg;

    // Default sizes of the wheel.
    localparam int unsigned WHEEL_SLOTS_DEF    = 2560;
    localparam int unsigned BUCKET_ENTRIES_DEF = 16;

    // At most this many entries are listed for one read.
    localparam int unsigned MAX_LIST = 16;

    // Field widths.
    localparam int unsigned UID_W    = 16;
    localparam int unsigned RID_W    = 6;
    localparam int unsigned KEY_W    = UID_W + RID_W;
    localparam int unsigned PERIOD_W = 12;
    localparam int unsigned OFFSET_W = 12;
    localparam int unsigned SLOT_W   = 20;
    localparam int unsigned BKT_W    = OFFSET_W + 1;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_ENTRY = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_DUP     = 2'd1;
    localparam status_t ST_MISSING = 2'd2;
    localparam status_t ST_FULL    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_item;
        logic    mod_step;
        logic    bucket_from_rem;
        logic    cnt_latch;
        logic    sweep_wr;
        logic    idx_clr;
        logic    idx_inc;
        logic    pos_latch;
        logic    ent_rd_last;
        logic    add_wr;
        logic    rm_wr;
        logic    st_set;
        status_t st_code;
        logic    bucket_next;
        logic    out_ack;
        logic    out_entry;
        logic    out_empty;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        action_t action;
        logic    bucket_out;
        logic    period_zero;
        logic    scan_done;
        logic    match;
        logic    bucket_full;
        logic    sweep_done;
        logic    mod_last;
        logic    list_empty;
        logic    list_last;
        logic    out_busy;
    } sts_t;

endpackage

/* rtl/core/psw_ram.sv */
// Generic simple dual-port RAM with a registered read.
module psw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/psw_ctrl.sv */
// Controller state machine of the periodic slot wheel table.
module psw_ctrl import psw_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_B_START,
        S_B_LATCH,
        S_SCAN,
        S_CMP,
        S_RM_WR,
        S_NEXT,
        S_ACK,
        S_WAIT_OUT,
        S_MOD,
        S_R_BUCKET,
        S_R_CNT,
        S_R_LATCH,
        S_R_CHECK,
        S_R_ISSUE,
        S_R_DATA,
        S_R_WAIT,
        S_CLR
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.st_code = ST_OK;
        unique case (state_reg)
            S_INIT: begin
                cmd.sweep_wr = 1'b1;
                if (sts.sweep_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (sts.action)
                    ACT_ADD, ACT_REMOVE: state_next = S_B_START;
                    ACT_READ:            state_next = S_MOD;
                    ACT_CLEAR:           state_next = S_CLR;
                endcase
            end
            // The count read address is the current bucket.
            S_B_START: begin
                if (sts.bucket_out) begin
                    state_next = S_ACK;
                end else begin
                    state_next = S_B_LATCH;
                end
            end
            S_B_LATCH: begin
                cmd.cnt_latch = 1'b1;
                cmd.idx_clr   = 1'b1;
                state_next    = S_SCAN;
            end
            // The entry at the scan index is read while in this state.
            S_SCAN: begin
                if (sts.scan_done) begin
                    state_next = S_NEXT;
                    if (sts.action == ACT_ADD) begin
                        if (sts.bucket_full) begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_FULL;
                        end else begin
                            cmd.add_wr = 1'b1;
                        end
                    end else begin
                        cmd.st_set  = 1'b1;
                        cmd.st_code = ST_MISSING;
                    end
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (sts.match) begin
                    cmd.pos_latch = 1'b1;
                    if (sts.action == ACT_ADD) begin
                        cmd.st_set  = 1'b1;
                        cmd.st_code = ST_DUP;
                        state_next  = S_NEXT;
                    end else begin
                        cmd.ent_rd_last = 1'b1;
                        state_next      = S_RM_WR;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_RM_WR: begin
                cmd.rm_wr  = 1'b1;
                state_next = S_NEXT;
            end
            S_NEXT: begin
                if (sts.period_zero) begin
                    state_next = S_ACK;
                end else begin
                    cmd.bucket_next = 1'b1;
                    state_next      = S_B_START;
                end
            end
            S_ACK: begin
                cmd.out_ack = 1'b1;
                state_next  = S_WAIT_OUT;
            end
            S_WAIT_OUT: begin
                if (!sts.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            // Slot reduction modulo the wheel size: reciprocal multiply, then subtract.
            S_MOD: begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last) begin
                    state_next = S_R_BUCKET;
                end
            end
            S_R_BUCKET: begin
                cmd.bucket_from_rem = 1'b1;
                state_next          = S_R_CNT;
            end
            S_R_CNT: begin
                state_next = S_R_LATCH;
            end
            S_R_LATCH: begin
                cmd.cnt_latch = 1'b1;
                cmd.idx_clr   = 1'b1;
                state_next    = S_R_CHECK;
            end
            S_R_CHECK: begin
                if (sts.list_empty) begin
                    cmd.out_empty = 1'b1;
                    state_next    = S_WAIT_OUT;
                end else begin
                    state_next = S_R_ISSUE;
                end
            end
            S_R_ISSUE: begin
                state_next = S_R_DATA;
            end
            S_R_DATA: begin
                cmd.out_entry = 1'b1;
                state_next    = S_R_WAIT;
            end
            S_R_WAIT: begin
                if (!sts.out_busy) begin
                    if (sts.list_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_R_ISSUE;
                    end
                end
            end
            S_CLR: begin
                cmd.sweep_wr = 1'b1;
                if (sts.sweep_done) begin
                    state_next = S_ACK;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/psw_dp.sv */
// Datapath of the periodic slot wheel table: item registers, memories and result register.
module psw_dp import psw_pkg::*; #(
    parameter int unsigned WHEEL_SLOTS    = WHEEL_SLOTS_DEF,
    parameter int unsigned BUCKET_ENTRIES = BUCKET_ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [1:0]          s_action,
    input  logic [UID_W-1:0]    s_user_id,
    input  logic [RID_W-1:0]    s_resource_id,
    input  logic [PERIOD_W-1:0] s_period,
    input  logic [OFFSET_W-1:0] s_first_offset,
    input  logic [SLOT_W-1:0]   s_slot_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_kind,
    output logic [UID_W-1:0]    m_entry_user_id,
    output logic [RID_W-1:0]    m_entry_resource_id,
    output logic [1:0]          m_status,
    output logic                m_last
);

    localparam int unsigned BW = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
    localparam int unsigned ENT_DEPTH = WHEEL_SLOTS * BUCKET_ENTRIES;
    localparam int unsigned AW = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;
    localparam int unsigned CW = $clog2(BUCKET_ENTRIES + 1);
    localparam int unsigned LIST_CAP =
        (BUCKET_ENTRIES < MAX_LIST) ? BUCKET_ENTRIES : MAX_LIST;
    localparam int unsigned KW = 1;
    localparam logic [31:0] WS32 = 32'(WHEEL_SLOTS);

    // Scaled reciprocal of the wheel size; with this scale the quotient of any slot is exact.
    localparam int unsigned RS = SLOT_W + BW;
    localparam int unsigned MW = SLOT_W + 2;
    localparam int unsigned PW = SLOT_W + MW;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << RS) + 64'(WHEEL_SLOTS) - 64'd1) / 64'(WHEEL_SLOTS);
    localparam logic [MW-1:0] RECIP = MW'(RECIP64);

    action_t              action_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [PERIOD_W-1:0]  period_reg;
    logic [BKT_W-1:0]     bucket_reg;
    logic [SLOT_W-1:0]    rem_reg;
    logic [KW-1:0]        k_reg;
    logic [PW-1:0]        prod_reg;
    logic [CW-1:0]        n_reg;
    logic [CW-1:0]        idx_reg;
    logic [CW-1:0]        pos_reg;
    status_t              st_reg;
    logic [BW-1:0]        sweep_reg;
    logic                 m_valid_reg;
    kind_t                m_kind_reg;
    logic [UID_W-1:0]     m_uid_reg;
    logic [RID_W-1:0]     m_rid_reg;
    status_t              m_status_reg;
    logic                 m_last_reg;

    logic [AW-1:0]        base;
    logic [AW-1:0]        ent_raddr;
    logic [AW-1:0]        ent_waddr;
    logic [KEY_W-1:0]     ent_wdata;
    logic [KEY_W-1:0]     ent_rdata;
    logic                 ent_we;
    logic                 cnt_we;
    logic [BW-1:0]        cnt_waddr;
    logic [CW-1:0]        cnt_wdata;
    logic [CW-1:0]        cnt_rdata;
    logic [CW-1:0]        list_n;
    logic [SLOT_W-1:0]    quo;
    logic [SLOT_W-1:0]    quo_ws;

    // Entry addresses inside the current bucket.
    assign base      = AW'(bucket_reg[BW-1:0]) * AW'(BUCKET_ENTRIES);
    assign ent_raddr = cmd.ent_rd_last ? (base + AW'(n_reg - CW'(1)))
                                       : (base + AW'(idx_reg));
    assign ent_waddr = cmd.add_wr ? (base + AW'(n_reg)) : (base + AW'(pos_reg));
    assign ent_wdata = cmd.add_wr ? key_reg : ent_rdata;
    assign ent_we    = cmd.add_wr | cmd.rm_wr;

    // Bucket counts: cleared by the sweep, bumped by add and remove.
    assign cnt_we    = cmd.sweep_wr | cmd.add_wr | cmd.rm_wr;
    assign cnt_waddr = cmd.sweep_wr ? sweep_reg : bucket_reg[BW-1:0];
    always_comb begin
        priority if (cmd.sweep_wr) begin
            cnt_wdata = '0;
        end else if (cmd.add_wr) begin
            cnt_wdata = n_reg + CW'(1);
        end else begin
            cnt_wdata = n_reg - CW'(1);
        end
    end

    psw_ram #(.WIDTH(KEY_W), .DEPTH(ENT_DEPTH)) u_ent_ram (
        .aclk  (aclk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    psw_ram #(.WIDTH(CW), .DEPTH(WHEEL_SLOTS)) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (bucket_reg[BW-1:0]),
        .rdata (cnt_rdata)
    );

    // Quotient of the slot by the wheel size, and the part of the slot it covers.
    assign quo    = SLOT_W'(prod_reg >> RS);
    assign quo_ws = SLOT_W'(quo * SLOT_W'(WHEEL_SLOTS));

    assign list_n = (n_reg > CW'(LIST_CAP)) ? CW'(LIST_CAP) : n_reg;

    // Item, scan and status registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            action_reg <= action_t'(s_action);
            key_reg    <= {s_user_id, s_resource_id};
            period_reg <= s_period;
            bucket_reg <= BKT_W'(s_first_offset);
            rem_reg    <= s_slot_index;
            k_reg      <= KW'(1);
            st_reg     <= ST_OK;
        end
        // Two-step reduction: reciprocal multiply, then subtract the covered part.
        if (cmd.mod_step) begin
            if (k_reg != '0) begin
                prod_reg <= PW'(rem_reg) * PW'(RECIP);
            end else begin
                rem_reg <= rem_reg - quo_ws;
            end
            k_reg <= k_reg - KW'(1);
        end
        if (cmd.bucket_from_rem) begin
            bucket_reg <= BKT_W'(rem_reg);
        end
        if (cmd.bucket_next) begin
            bucket_reg <= bucket_reg + BKT_W'(period_reg);
        end
        if (cmd.cnt_latch) begin
            n_reg <= cnt_rdata;
        end
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + CW'(1);
        end
        if (cmd.pos_latch) begin
            pos_reg <= idx_reg;
        end
        if (cmd.st_set && (cmd.st_code > st_reg)) begin
            st_reg <= cmd.st_code;
        end
    end

    // Clearing sweep pointer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
        end else if (cmd.sweep_wr) begin
            sweep_reg <= sts.sweep_done ? '0 : sweep_reg + BW'(1);
        end
    end

    // Result register: holds one beat until the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_ack || cmd.out_entry || cmd.out_empty) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ack) begin
            m_kind_reg   <= KIND_ACK;
            m_uid_reg    <= '0;
            m_rid_reg    <= '0;
            m_status_reg <= st_reg;
            m_last_reg   <= 1'b1;
        end else if (cmd.out_empty) begin
            m_kind_reg   <= KIND_EMPTY;
            m_uid_reg    <= '0;
            m_rid_reg    <= '0;
            m_status_reg <= ST_OK;
            m_last_reg   <= 1'b1;
        end else if (cmd.out_entry) begin
            m_kind_reg   <= KIND_ENTRY;
            m_uid_reg    <= ent_rdata[KEY_W-1:RID_W];
            m_rid_reg    <= ent_rdata[RID_W-1:0];
            m_status_reg <= ST_OK;
            m_last_reg   <= sts.list_last;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_kind              = m_kind_reg;
    assign m_entry_user_id     = m_uid_reg;
    assign m_entry_resource_id = m_rid_reg;
    assign m_status            = m_status_reg;
    assign m_last              = m_last_reg;

    // Status toward the controller.
    always_comb begin
        sts.action      = action_reg;
        sts.bucket_out  = (bucket_reg >= BKT_W'(WHEEL_SLOTS));
        sts.period_zero = (period_reg == '0);
        sts.scan_done   = (idx_reg == n_reg);
        sts.match       = (ent_rdata == key_reg);
        sts.bucket_full = (n_reg >= CW'(BUCKET_ENTRIES));
        sts.sweep_done  = (sweep_reg == BW'(WHEEL_SLOTS - 1));
        sts.mod_last    = (k_reg == '0);
        sts.list_empty  = (n_reg == '0);
        sts.list_last   = ((idx_reg + CW'(1)) == list_n);
        sts.out_busy    = m_valid_reg;
    end

    // A new result is never loaded over one that waits.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_ack || cmd.out_entry || cmd.out_empty) |-> !m_valid_reg)
        else $error("result loaded while previous beat pending");

    // Only acknowledges carry a nonzero status.
    a_status_ack_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_kind_reg != KIND_ACK)) |-> (m_status_reg == ST_OK))
        else $error("listed or empty beat with nonzero status");

    // A bucket count never exceeds the bucket size.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_latch |=> (n_reg <= CW'(BUCKET_ENTRIES)))
        else $error("bucket count out of range");

    // The reduced slot names a bucket of the wheel.
    a_mod_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.bucket_from_rem |-> (32'(rem_reg) < WS32))
        else $error("slot reduction left a remainder too large");

endmodule

/* rtl/core/periodic_slot_wheel_table.sv */
// Top level of the periodic slot wheel table.
//
// The wheel keeps WHEEL_SLOTS buckets of up to BUCKET_ENTRIES (user id, resource id)
// entries in one entry RAM plus a bucket count RAM, both worked by a single
// controller, so one item is handled at a time. After reset, and for every clear
// item, the count RAM is swept one bucket per cycle, and no item is taken while
// the sweep runs. An add or remove reads the count of each bucket touched and
// scans the stored entries of that bucket (one registered RAM read and one
// compare per entry), then sends the acknowledge. A read reduces the slot modulo
// WHEEL_SLOTS (a reciprocal multiply, then a multiply and subtract), fetches the
// count, then lists each entry, waiting until the sink takes each beat.
module periodic_slot_wheel_table import psw_pkg::*; #(
    parameter int unsigned WHEEL_SLOTS    = WHEEL_SLOTS_DEF,
    parameter int unsigned BUCKET_ENTRIES = BUCKET_ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_action,
    input  logic [UID_W-1:0]    s_user_id,
    input  logic [RID_W-1:0]    s_resource_id,
    input  logic [PERIOD_W-1:0] s_period,
    input  logic [OFFSET_W-1:0] s_first_offset,
    input  logic [SLOT_W-1:0]   s_slot_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_kind,
    output logic [UID_W-1:0]    m_entry_user_id,
    output logic [RID_W-1:0]    m_entry_resource_id,
    output logic [1:0]          m_status,
    output logic                m_last
);

    cmd_t cmd;
    sts_t sts;

    // Sequencing of each item.
    psw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Storage, scan and result logic.
    psw_dp #(
        .WHEEL_SLOTS    (WHEEL_SLOTS),
        .BUCKET_ENTRIES (BUCKET_ENTRIES)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .s_action            (s_action),
        .s_user_id           (s_user_id),
        .s_resource_id       (s_resource_id),
        .s_period            (s_period),
        .s_first_offset      (s_first_offset),
        .s_slot_index        (s_slot_index),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_kind              (m_kind),
        .m_entry_user_id     (m_entry_user_id),
        .m_entry_resource_id (m_entry_resource_id),
        .m_status            (m_status),
        .m_last              (m_last)
    );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the periodic slot wheel table.
module testbench;
    import psw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOTS  = 2560;
    localparam int NDEPTH  = 16;
    localparam int NRANDOM = 450;

    typedef struct {
        action_t           act;
        logic [UID_W-1:0]  uid;
        logic [RID_W-1:0]  rid;
        logic [PERIOD_W-1:0] per;
        logic [OFFSET_W-1:0] off;
        logic [SLOT_W-1:0] slot;
    } wheel_op_t;

    typedef struct {
        kind_t             kind;
        logic [UID_W-1:0]  uid;
        logic [RID_W-1:0]  rid;
        status_t           st;
        logic              last;
    } wheel_beat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_action = '0;
    logic [UID_W-1:0] s_user_id = '0;
    logic [RID_W-1:0] s_resource_id = '0;
    logic [PERIOD_W-1:0] s_period = '0;
    logic [OFFSET_W-1:0] s_first_offset = '0;
    logic [SLOT_W-1:0] s_slot_index = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_kind;
    logic [UID_W-1:0] m_entry_user_id;
    logic [RID_W-1:0] m_entry_resource_id;
    logic [1:0] m_status;
    logic m_last;

    // Shadow copy of the wheel contents.
    logic [KEY_W-1:0] shadow_keys [NSLOTS][NDEPTH];
    int shadow_cnt [NSLOTS];

    wheel_op_t   pending_ops[$];
    wheel_beat_t expected_beats[$];
    int errors = 0;
    int ops_taken = 0;
    int beats_seen = 0;
    logic [UID_W-1:0] uid_pool [6];
    logic [RID_W-1:0] rid_pool [6];

    periodic_slot_wheel_table u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_user_id(s_user_id), .s_resource_id(s_resource_id),
        .s_period(s_period), .s_first_offset(s_first_offset),
        .s_slot_index(s_slot_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_entry_user_id(m_entry_user_id), .m_entry_resource_id(m_entry_resource_id),
        .m_status(m_status), .m_last(m_last)
    );

    // Clock and reset.
    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    task automatic report(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void push_beat(kind_t k, logic [UID_W-1:0] u, logic [RID_W-1:0] r,
                                      status_t s, logic l);
        wheel_beat_t b;
        b.kind = k;
        b.uid = u;
        b.rid = r;
        b.st = s;
        b.last = l;
        expected_beats = {expected_beats, b};
    endfunction

    // Append one item to the queue of pending items.
    function automatic void queue_op(wheel_op_t op);
        pending_ops = {pending_ops, op};
    endfunction

    // Work out the beats that one accepted item causes and update the shadow wheel.
    function automatic void predict_wheel(wheel_op_t op);
        logic [KEY_W-1:0] key;
        status_t st;
        status_t s;
        int b;
        int pos;
        int n;
        key = {op.uid, op.rid};
        case (op.act)
            ACT_ADD, ACT_REMOVE: begin
                st = ST_OK;
                b = op.off;
                while (b < NSLOTS) begin
                    pos = -1;
                    for (int i = 0; i < shadow_cnt[b]; i++) begin
                        if (pos < 0 && shadow_keys[b][i] == key) pos = i;
                    end
                    n = shadow_cnt[b];
                    if (op.act == ACT_ADD) begin
                        if (pos >= 0) begin
                            s = ST_DUP;
                        end else if (n >= NDEPTH) begin
                            s = ST_FULL;
                        end else begin
                            shadow_keys[b][n] = key;
                            shadow_cnt[b] = n + 1;
                            s = ST_OK;
                        end
                    end else if (pos < 0) begin
                        s = ST_MISSING;
                    end else begin
                        // Swap the last entry into the freed position.
                        shadow_keys[b][pos] = shadow_keys[b][n-1];
                        shadow_cnt[b] = n - 1;
                        s = ST_OK;
                    end
                    if (s > st) st = s;
                    if (op.per == 0) break;
                    b += op.per;
                end
                push_beat(KIND_ACK, '0, '0, st, 1'b1);
            end
            ACT_READ: begin
                b = op.slot % NSLOTS;
                n = shadow_cnt[b];
                if (n == 0) begin
                    push_beat(KIND_EMPTY, '0, '0, ST_OK, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        push_beat(KIND_ENTRY, shadow_keys[b][i][KEY_W-1:RID_W],
                                  shadow_keys[b][i][RID_W-1:0], ST_OK, i == n - 1);
                    end
                end
            end
            default: begin
                for (int i = 0; i < NSLOTS; i++) shadow_cnt[i] = 0;
                push_beat(KIND_ACK, '0, '0, ST_OK, 1'b1);
            end
        endcase
    endfunction

    // No idling on either side while the calm window of items is passing.
    function automatic bit want_idle();
        if (ops_taken >= 150 && ops_taken < 260) return 1'b0;
        return $urandom_range(99) < 23;
    endfunction

    // Driver: presents queued items and predicts the beats of each accepted item.
    always @(posedge aclk) begin
        wheel_op_t op;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                op.act = action_t'(s_action);
                op.uid = s_user_id;
                op.rid = s_resource_id;
                op.per = s_period;
                op.off = s_first_offset;
                op.slot = s_slot_index;
                predict_wheel(op);
                ops_taken <= ops_taken + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending_ops.size() > 0 && !want_idle()) begin
                    op = pending_ops.pop_front();
                    s_action <= op.act;
                    s_user_id <= op.uid;
                    s_resource_id <= op.rid;
                    s_period <= op.per;
                    s_first_offset <= op.off;
                    s_slot_index <= op.slot;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat and paces the sink, with one long hold-off.
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge aclk) begin
        wheel_beat_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                beats_seen <= beats_seen + 1;
                if (expected_beats.size() == 0) begin
                    report("unexpected beat kind", m_kind, -1);
                end else begin
                    want = expected_beats.pop_front();
                    if (m_kind != want.kind) report("kind", m_kind, want.kind);
                    if (m_entry_user_id != want.uid)
                        report("user id", m_entry_user_id, want.uid);
                    if (m_entry_resource_id != want.rid)
                        report("resource id", m_entry_resource_id, want.rid);
                    if (m_status != want.st) report("status", m_status, want.st);
                    if (m_last != want.last) report("last", m_last, want.last);
                end
            end
            if (!hold_done && beats_seen >= 100) begin
                hold_done <= 1'b1;
                hold_left <= 600;
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !want_idle();
            end
        end
    end

    function automatic wheel_op_t make_op(action_t a, int u, int r, int p, int o, int s);
        wheel_op_t op;
        op.act = a;
        op.uid = UID_W'(u);
        op.rid = RID_W'(r);
        op.per = PERIOD_W'(p);
        op.off = OFFSET_W'(o);
        op.slot = SLOT_W'(s);
        return op;
    endfunction

    // Random item: mostly a small pool of keys and buckets so entries collide.
    function automatic wheel_op_t random_op();
        wheel_op_t op;
        int pick;
        int k;
        int offs [5] = '{5, 7, 300, 2559, 1285};
        int pers [6] = '{0, 256, 640, 1280, 2560, 4095};
        pick = $urandom_range(99);
        k = $urandom_range(5);
        op.uid = ($urandom_range(9) == 0) ? UID_W'($urandom) : uid_pool[k];
        op.rid = ($urandom_range(9) == 0) ? RID_W'($urandom) : rid_pool[k];
        op.per = ($urandom_range(9) == 0) ? PERIOD_W'($urandom_range(4095, 200))
                                          : PERIOD_W'(pers[$urandom_range(5)]);
        op.off = ($urandom_range(9) == 0) ? OFFSET_W'($urandom_range(4095))
                                          : OFFSET_W'(offs[$urandom_range(4)]);
        op.slot = ($urandom_range(4) == 0) ? SLOT_W'($urandom)
                  : SLOT_W'(offs[$urandom_range(3)] + NSLOTS * $urandom_range(408));
        if (pick < 40) op.act = ACT_ADD;
        else if (pick < 65) op.act = ACT_REMOVE;
        else if (pick < 97) op.act = ACT_READ;
        else op.act = ACT_CLEAR;
        return op;
    endfunction

    // Wait until the block has delivered every expected beat.
    task automatic drain();
        do begin
            @(posedge aclk);
            #1;
        end while (pending_ops.size() != 0 || s_valid || expected_beats.size() != 0);
    endtask

    // Stimulus.
    initial begin
        for (int i = 0; i < 6; i++) begin
            uid_pool[i] = UID_W'($urandom);
            rid_pool[i] = RID_W'($urandom);
        end
        uid_pool[0] = '1;
        rid_pool[0] = '1;
        uid_pool[1] = '0;
        rid_pool[1] = '0;

        // Directed: extremes, duplicates, misses, period zero, offset past the wheel.
        queue_op(make_op(ACT_READ, 0, 0, 1, 0, 0));
        queue_op(make_op(ACT_ADD, 65535, 63, 2560, 2559, 0));
        queue_op(make_op(ACT_ADD, 0, 0, 2560, 0, 0));
        queue_op(make_op(ACT_ADD, 65535, 63, 4095, 2559, 0));
        queue_op(make_op(ACT_READ, 0, 0, 1, 0, 2559));
        queue_op(make_op(ACT_READ, 0, 0, 1, 0, 1048575));
        queue_op(make_op(ACT_REMOVE, 1234, 5, 2560, 0, 0));
        queue_op(make_op(ACT_ADD, 77, 9, 0, 1535, 0));
        queue_op(make_op(ACT_ADD, 88, 10, 0, 4095, 0));
        queue_op(make_op(ACT_ADD, 99, 11, 1, 2550, 0));
        queue_op(make_op(ACT_ADD, 42, 42, 1, 0, 0));
        queue_op(make_op(ACT_READ, 0, 0, 1, 0, 1048575));
        queue_op(make_op(ACT_REMOVE, 42, 42, 1, 0, 0));
        // Fill one bucket past its depth, then list it.
        for (int i = 0; i < NDEPTH + 1; i++)
            queue_op(make_op(ACT_ADD, 1000 + i, i, 0, 9, 0));
        queue_op(make_op(ACT_READ, 0, 0, 1, 0, 9 + 2560 * 7));
        // A duplicate, then a new key, in the full bucket; each also lands in a free bucket: the larger code wins.
        queue_op(make_op(ACT_ADD, 1000, 0, 1280, 9, 0));
        queue_op(make_op(ACT_ADD, 5, 5, 1280, 9, 0));
        queue_op(make_op(ACT_REMOVE, 1003, 3, 0, 9, 0));
        queue_op(make_op(ACT_READ, 0, 0, 1, 0, 9));
        queue_op(make_op(ACT_CLEAR, 0, 0, 1, 0, 0));
        queue_op(make_op(ACT_READ, 0, 0, 1, 0, 9));
        drain();

        // Random part, with one pause until the block is drained.
        for (int i = 0; i < NRANDOM; i++) begin
            if (i == NRANDOM / 2) drain();
            queue_op(random_op());
        end
        drain();
        repeat (200) @(posedge aclk);
        if (expected_beats.size() != 0) begin
            report("beats still outstanding", expected_beats.size(), 0);
        end
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #100_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
